>>> design/mfh_pkg.sv
// Package for the message fragmenter: constants, part codes, register indexes
// and the result word type.
// No dependencies; compile first.
package mfh_pkg;

  // Message length bits taken from a start word
  localparam int LenBits = 32;
  // Configuration register index width
  localparam int CfgIndexBits = 8;
  // Deepest result burst caused by one input word
  localparam int BurstDepth = 5;
  localparam int BurstCountBits = $clog2(BurstDepth + 1);

  localparam logic [15:0] MaxPayloadReset = 16'd65503;

  // Part codes ORed into the first header byte
  localparam logic [7:0] PartSingle = 8'h30;
  localparam logic [7:0] PartBegin  = 8'h00;
  localparam logic [7:0] PartMiddle = 8'h10;
  localparam logic [7:0] PartEnd    = 8'h20;

  // Input word kinds
  localparam logic KindStart = 1'b0;
  localparam logic KindData  = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIndexBits-1:0] RegPlatformId  = 8'd0;
  localparam logic [CfgIndexBits-1:0] RegChannelId   = 8'd1;
  localparam logic [CfgIndexBits-1:0] RegCompactMode = 8'd2;
  localparam logic [CfgIndexBits-1:0] RegMaxPayload  = 8'd3;

  // One result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       fragment_end;
    logic       message_end;
    logic       oversize_error;
  } res_t;

endpackage

>>> design/mfh_if.sv
// Channel interfaces of the message fragmenter: input words, result words
// and configuration writes. Depends on mfh_pkg.
interface mfh_in_if import mfh_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [31:0]        message_length;
  logic [7:0]         data_byte;

  modport source (output valid, kind, message_length, data_byte, input ready);
  modport sink   (input valid, kind, message_length, data_byte, output ready);
endinterface

interface mfh_out_if import mfh_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       fragment_end;
  logic       message_end;
  logic       oversize_error;

  modport source (output valid, out_byte, fragment_end, message_end, oversize_error,
                  input ready);
  modport sink   (input valid, out_byte, fragment_end, message_end, oversize_error,
                  output ready);
endinterface

interface mfh_cfg_if import mfh_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CfgIndexBits-1:0] index;
  logic [15:0]             data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/message_fragmenter_with_header.sv
// Message fragmenter with sequence header: splits a message byte stream into
// fragments, each led by a two- or four-byte header. Depends on mfh_pkg, mfh_if.
//
// Each accepted input word is turned at once into a burst of up to five result
// words held in a five-entry output register, which then drains one word per
// cycle while the receiver is ready. A new input word is taken when the burst
// is empty or its last word is leaving, so data bytes flow at one per cycle when
// the output does not stall. A data byte that closes a fragment (byte plus
// four-byte header) or a start word (full header, compact header or oversize flag)
// holds the input until its burst drains; stray or dropped data causes no result.
// Configuration writes are accepted in every cycle.
module message_fragmenter_with_header import mfh_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  mfh_cfg_if.sink      cfg,
  mfh_in_if.sink       msg,
  mfh_out_if.source    frag
);

  typedef struct packed {
    res_t [3:0]  b;
    logic [15:0] fbl;
  } hdr_t;

  // Configuration registers
  logic [7:0]  platform_id;
  logic [7:0]  channel_id;
  logic        compact_mode;
  logic [15:0] max_payload;

  // Message state
  logic [15:0]        sequence_counter, sequence_counter_next;
  logic [LenBits-1:0] bytes_remaining, bytes_remaining_next;
  logic [15:0]        fragment_bytes_left, fragment_bytes_left_next;
  logic               first_fragment_done, first_fragment_done_next;
  logic               dropping, dropping_next;

  // Result burst register
  res_t [BurstDepth-1:0]     burst, burst_new;
  logic [BurstCountBits-1:0] count, count_new;

  logic               in_take, out_take;
  logic [15:0]        lim;
  logic [LenBits-1:0] len_in, br_dec;
  logic [15:0]        fbl_dec;
  hdr_t               hdr_start, hdr_cont;

  // Builds a header for a fragment with br bytes still to come
  function automatic hdr_t make_header(input logic [LenBits-1:0] br, input logic ffd,
                                       input logic compact, input logic [15:0] lm,
                                       input logic [7:0] plat, input logic [7:0] chan,
                                       input logic [15:0] seq);
    hdr_t h;
    logic last, empty;
    logic [7:0] code;
    last  = br <= {{(LenBits-16){1'b0}}, lm};
    empty = br == '0;
    h.fbl = last ? br[15:0] : lm;
    if (compact) begin
      code = PartBegin;
    end else if (!ffd) begin
      code = last ? PartSingle : PartBegin;
    end else begin
      code = last ? PartEnd : PartMiddle;
    end
    h.b[0] = '{out_byte: plat | code, fragment_end: 1'b0, message_end: 1'b0,
               oversize_error: 1'b0};
    if (compact) begin
      h.b[1] = '{out_byte: chan, fragment_end: empty, message_end: empty,
                 oversize_error: 1'b0};
    end else begin
      h.b[1] = '{out_byte: chan, fragment_end: 1'b0, message_end: 1'b0,
                 oversize_error: 1'b0};
    end
    h.b[2] = '{out_byte: seq[15:8], fragment_end: 1'b0, message_end: 1'b0,
               oversize_error: 1'b0};
    h.b[3] = '{out_byte: seq[7:0], fragment_end: empty, message_end: empty,
               oversize_error: 1'b0};
    return h;
  endfunction

  // Handshakes
  assign cfg.ready  = 1'b1;
  assign out_take   = frag.valid && frag.ready;
  assign msg.ready  = (count == '0) ||
                      (count == BurstCountBits'(1) && frag.ready);
  assign in_take    = msg.valid && msg.ready;

  assign frag.valid          = count != '0;
  assign frag.out_byte       = burst[0].out_byte;
  assign frag.fragment_end   = burst[0].fragment_end;
  assign frag.message_end    = burst[0].message_end;
  assign frag.oversize_error = burst[0].oversize_error;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      platform_id  <= '0;
      channel_id   <= '0;
      compact_mode <= 1'b0;
      max_payload  <= MaxPayloadReset;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        RegPlatformId:  platform_id  <= cfg.data[7:0];
        RegChannelId:   channel_id   <= cfg.data[7:0];
        RegCompactMode: compact_mode <= cfg.data[0];
        RegMaxPayload:  max_payload  <= cfg.data;
        default: ;
      endcase
    end
  end

  // Shared terms
  assign lim     = (max_payload == '0) ? 16'd1 : max_payload;
  assign len_in  = msg.message_length[LenBits-1:0];
  assign br_dec  = bytes_remaining - LenBits'(1);
  assign fbl_dec = (fragment_bytes_left != '0) ? fragment_bytes_left - 16'd1 : 16'd0;

  assign hdr_start = make_header(len_in, 1'b0, compact_mode, lim, platform_id,
                                 channel_id, sequence_counter);
  assign hdr_cont  = make_header(br_dec, first_fragment_done, 1'b0, lim, platform_id,
                                 channel_id, sequence_counter);

  // Next state and result burst for the word at the input
  always_comb begin
    sequence_counter_next    = sequence_counter;
    bytes_remaining_next     = bytes_remaining;
    fragment_bytes_left_next = fragment_bytes_left;
    first_fragment_done_next = first_fragment_done;
    dropping_next            = dropping;
    burst_new                = burst;
    count_new                = '0;
    if (msg.kind == KindStart) begin
      bytes_remaining_next     = len_in;
      first_fragment_done_next = 1'b0;
      dropping_next            = 1'b0;
      fragment_bytes_left_next = '0;
      if (compact_mode && (len_in > {{(LenBits-16){1'b0}}, lim})) begin
        // compact oversize: flag it and drop the bytes
        dropping_next = 1'b1;
        burst_new[0]  = '{out_byte: 8'h00, fragment_end: 1'b0, message_end: 1'b0,
                          oversize_error: 1'b1};
        count_new     = BurstCountBits'(1);
      end else begin
        fragment_bytes_left_next = hdr_start.fbl;
        first_fragment_done_next = 1'b1;
        burst_new[0] = hdr_start.b[0];
        if (compact_mode) begin
          burst_new[1] = hdr_start.b[1];
          count_new    = BurstCountBits'(2);
        end else begin
          burst_new[1] = hdr_start.b[1];
          burst_new[2] = hdr_start.b[2];
          burst_new[3] = hdr_start.b[3];
          count_new    = BurstCountBits'(4);
          sequence_counter_next = sequence_counter + 16'd1;
        end
      end
    end else if (bytes_remaining == '0) begin
      // stray data, no message open
      count_new = '0;
    end else if (dropping) begin
      bytes_remaining_next = br_dec;
      if (br_dec == '0) begin
        dropping_next = 1'b0;
      end
    end else begin
      bytes_remaining_next = br_dec;
      if (br_dec == '0) begin
        // last byte of the message
        fragment_bytes_left_next = '0;
        burst_new[0] = '{out_byte: msg.data_byte, fragment_end: 1'b1, message_end: 1'b1,
                         oversize_error: 1'b0};
        count_new    = BurstCountBits'(1);
      end else if (fbl_dec == '0) begin
        // fragment full: byte then next full header
        burst_new[0] = '{out_byte: msg.data_byte, fragment_end: 1'b1, message_end: 1'b0,
                         oversize_error: 1'b0};
        burst_new[1] = hdr_cont.b[0];
        burst_new[2] = hdr_cont.b[1];
        burst_new[3] = hdr_cont.b[2];
        burst_new[4] = hdr_cont.b[3];
        count_new    = BurstCountBits'(5);
        fragment_bytes_left_next = hdr_cont.fbl;
        first_fragment_done_next = 1'b1;
        sequence_counter_next    = sequence_counter + 16'd1;
      end else begin
        fragment_bytes_left_next = fbl_dec;
        burst_new[0] = '{out_byte: msg.data_byte, fragment_end: 1'b0, message_end: 1'b0,
                         oversize_error: 1'b0};
        count_new    = BurstCountBits'(1);
      end
    end
  end

  // Message state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_counter    <= '0;
      bytes_remaining     <= '0;
      fragment_bytes_left <= '0;
      first_fragment_done <= 1'b0;
      dropping            <= 1'b0;
    end else if (in_take) begin
      sequence_counter    <= sequence_counter_next;
      bytes_remaining     <= bytes_remaining_next;
      fragment_bytes_left <= fragment_bytes_left_next;
      first_fragment_done <= first_fragment_done_next;
      dropping            <= dropping_next;
    end
  end

  // Burst count: load on a new word, else count down as words leave
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_take) begin
      count <= count_new;
    end else if (out_take) begin
      count <= count - BurstCountBits'(1);
    end
  end

  // Burst payload: load, or shift towards the output slot
  always_ff @(posedge clk) begin
    if (in_take) begin
      burst <= burst_new;
    end else if (out_take) begin
      for (int i = 0; i < BurstDepth - 1; i++) begin
        burst[i] <= burst[i+1];
      end
    end
  end

endmodule
